// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GSW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GSW_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define GSW_ASSERT(lbl, clk, rstn, prop, msg)
`define GSW_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/gsw_pkg.sv =====
`default_nettype none
package gsw_pkg;

  localparam int SEG_STEPS  = 1024;
  localparam int MAX_COMP   = 5;
  localparam int NUM_WORDS  = 5;

  localparam int IDX_W      = 10;
  localparam int SMP_W      = 24;
  localparam int STEP_W     = 24;
  localparam int WORD_W     = 48;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;

  localparam int X_SHIFT    = 8;
  localparam int X_W        = IDX_W + STEP_W - X_SHIFT;
  localparam int MEAN_SHIFT = 8;
  localparam int D_W        = X_W + 2;
  localparam int AD_W       = X_W + 1;
  localparam int SQ_W       = 2 * AD_W;
  localparam int U_SHIFT    = 7;
  localparam int NUM_W      = SQ_W + U_SHIFT;
  localparam int SD_W       = 16;
  localparam int SD2_W      = 2 * SD_W - 1;
  localparam int U_W        = 21;
  localparam int U_MAX      = 1 << 20;
  localparam int REM_W      = SD2_W + U_W - 1;

  localparam int A_SHIFT    = 9;
  localparam int A_W        = U_W + A_SHIFT;
  localparam int EXP_Q      = 30;
  localparam int EXP_W      = EXP_Q + 1;
  localparam int SUM_W      = EXP_W + 1;
  localparam int TERMS      = 12;
  localparam int SQUARES    = 5;
  localparam int RCP_W      = 32;

  localparam int PROD_W     = SD_W + EXP_W;
  localparam int Y_SHIFT    = 26;
  localparam int CONTRIB_W  = PROD_W - Y_SHIFT + 1;
  localparam int ACC_W      = SMP_W + 3;

  localparam int DIV_LAT    = 1 + U_W;
  localparam int EXP_LAT    = 3 * TERMS + SQUARES;
  localparam int LANE_LAT   = 2 + DIV_LAT + EXP_LAT + 2;

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT,
    REG_STEP,
    REG_WORD0,
    REG_WORD1,
    REG_WORD2,
    REG_WORD3,
    REG_WORD4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SD_W-1:0] scale;
    logic signed [SD_W-1:0] mean;
    logic signed [SD_W-1:0] sd;
  } comp_word_t;

  typedef logic signed [CONTRIB_W-1:0] contrib_t;

endpackage
`default_nettype wire

// ===== rtl/gsw_if.sv =====
`default_nettype none
interface gsw_in_if import gsw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        time_index;
  logic signed [SMP_W-1:0] prior_value;
  modport source (output valid, time_index, prior_value, input ready);
  modport sink   (input valid, time_index, prior_value, output ready);
endinterface

interface gsw_out_if import gsw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_value;
  logic                    saturated;
  modport source (output valid, sample_value, saturated, input ready);
  modport sink   (input valid, sample_value, saturated, output ready);
endinterface

interface gsw_cfg_if import gsw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/gsw_div.sv =====
`default_nettype none
module gsw_div
  import gsw_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SQ_W-1:0]    sq_i,
  input  logic [SD2_W-1:0]   sd2_i,
  output logic [U_W-1:0]     u_o,
  output logic               kill_o
);

  logic [NUM_W-1:0]       num;
  logic [NUM_W-U_W-1:0]   sd2_hi;
  logic [REM_W-1:0]       sd2_ext;
  logic [REM_W-1:0]       rem_q [0:U_W];
  logic [U_W-1:0]         quo_q [0:U_W];
  logic                   kill_q [0:U_W];

  assign num     = {sq_i, {U_SHIFT{1'b0}}};
  assign sd2_hi  = {{(NUM_W-U_W-SD2_W){1'b0}}, sd2_i};
  assign sd2_ext = {{(REM_W-SD2_W){1'b0}}, sd2_i};

  // A quotient that would need more than U_W bits is past the tail anyway.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num[REM_W-1:0];
      quo_q[0]  <= '0;
      kill_q[0] <= (num[NUM_W-1:U_W] >= sd2_hi);
    end
  end

  for (genvar j = 1; j <= U_W; j++) begin : g_step
    localparam int B = U_W - j;
    logic [REM_W-1:0] dsh;
    logic             ge;

    assign dsh = sd2_ext << B;
    assign ge  = (rem_q[j-1] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (rem_q[j-1] - dsh) : rem_q[j-1];
        quo_q[j]  <= quo_q[j-1] | (U_W'(ge) << B);
        kill_q[j] <= kill_q[j-1];
      end
    end
  end

  assign u_o    = quo_q[U_W];
  assign kill_o = kill_q[U_W] || (quo_q[U_W] > U_W'(U_MAX));

endmodule
`default_nettype wire

// ===== rtl/gsw_exp.sv =====
`default_nettype none
module gsw_exp
  import gsw_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [U_W-1:0]   u_i,
  input  logic             kill_i,
  output logic [EXP_W-1:0] y_o,
  output logic             kill_o
);

  localparam int TA_W = EXP_W + A_W;
  localparam int PB_W = EXP_W + RCP_W;
  localparam int KQ_W = EXP_W + 4;

  logic [A_W-1:0]          a_q    [1:TERMS];
  logic [EXP_W-1:0]        term_q [1:TERMS];
  logic signed [SUM_W-1:0] sum_q  [1:TERMS];
  logic                    kill_q [1:TERMS];
  logic [EXP_W-1:0]        y_q    [1:SQUARES];
  logic                    ks_q   [1:SQUARES];

  for (genvar t = 1; t <= TERMS; t++) begin : g_term
    localparam int K = t;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_W) - 64'd1) / 64'(K));

    logic [A_W-1:0]          a_in;
    logic [EXP_W-1:0]        term_in;
    logic signed [SUM_W-1:0] sum_in;
    logic                    kill_in;

    logic [TA_W-1:0]         pa_q;
    logic [A_W-1:0]          a1_q;
    logic signed [SUM_W-1:0] sum1_q;
    logic                    kill1_q;

    logic [EXP_W-1:0]        p;
    logic [PB_W-1:0]         pb_q;
    logic [EXP_W-1:0]        p2_q;
    logic [A_W-1:0]          a2_q;
    logic signed [SUM_W-1:0] sum2_q;
    logic                    kill2_q;

    logic [EXP_W-1:0]        q0;
    logic [KQ_W-1:0]         qk;
    logic [KQ_W-1:0]         r;
    logic [EXP_W-1:0]        q;

    if (t == 1) begin : g_first
      assign a_in    = {u_i, {A_SHIFT{1'b0}}};
      assign term_in = EXP_W'(1) << EXP_Q;
      assign sum_in  = SUM_W'(1) << EXP_Q;
      assign kill_in = kill_i;
    end else begin : g_next
      assign a_in    = a_q[t-1];
      assign term_in = term_q[t-1];
      assign sum_in  = sum_q[t-1];
      assign kill_in = kill_q[t-1];
    end

    assign p  = pa_q[TA_W-1:EXP_Q];
    assign q0 = pb_q[PB_W-1:RCP_W];
    assign qk = KQ_W'(q0) * KQ_W'(K);
    assign r  = KQ_W'(p2_q) - qk;
    assign q  = q0 + EXP_W'(r >= KQ_W'(K));

    // The reciprocal estimate is at most one short, so one correction suffices.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q    <= TA_W'(term_in) * TA_W'(a_in);
        a1_q    <= a_in;
        sum1_q  <= sum_in;
        kill1_q <= kill_in;

        pb_q    <= PB_W'(p) * PB_W'(RCP);
        p2_q    <= p;
        a2_q    <= a1_q;
        sum2_q  <= sum1_q;
        kill2_q <= kill1_q;

        a_q[t]    <= a2_q;
        term_q[t] <= q;
        sum_q[t]  <= ((t % 2) == 1) ? (sum2_q - $signed({1'b0, q}))
                                     : (sum2_q + $signed({1'b0, q}));
        kill_q[t] <= kill2_q;
      end
    end
  end

  for (genvar s = 1; s <= SQUARES; s++) begin : g_square
    logic [EXP_W-1:0]   y_in;
    logic               k_in;
    logic [2*EXP_W-1:0] sq;

    if (s == 1) begin : g_first
      assign y_in = sum_q[TERMS][SUM_W-1] ? '0 : sum_q[TERMS][EXP_W-1:0];
      assign k_in = kill_q[TERMS];
    end else begin : g_next
      assign y_in = y_q[s-1];
      assign k_in = ks_q[s-1];
    end

    assign sq = (2*EXP_W)'(y_in) * (2*EXP_W)'(y_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[s]  <= sq[EXP_W+EXP_Q-1:EXP_Q];
        ks_q[s] <= k_in;
      end
    end
  end

  assign y_o    = y_q[SQUARES];
  assign kill_o = ks_q[SQUARES];

endmodule
`default_nettype wire

// ===== rtl/gsw_lane.sv =====
`default_nettype none
module gsw_lane
  import gsw_pkg::*;
(
  input  logic           clk_i,
  input  logic           en_i,
  input  comp_word_t     word_i,
  input  logic [X_W-1:0] x_i,
  output contrib_t       contrib_o
);

  localparam int MAG_W = PROD_W - Y_SHIFT;

  logic [SD_W-1:0]       asd;
  logic [SD_W-1:0]       as_d;
  logic [2*SD_W-1:0]     sd2_full;
  logic [SD2_W-1:0]      sd2_q;
  logic [SD_W-1:0]       as_q;
  logic                  neg_q;

  logic signed [D_W-1:0] d;
  logic [AD_W-1:0]       ad_d;
  logic [AD_W-1:0]       ad_q;
  logic [SQ_W-1:0]       sq_q;

  logic [U_W-1:0]        u;
  logic                  kill_div;
  logic [EXP_W-1:0]      y;
  logic                  kill_exp;

  logic [PROD_W-1:0]     prod_q;
  logic                  kill_q;
  logic [PROD_W-1:0]     rnd;
  logic [MAG_W-1:0]      mag;
  contrib_t              cm;
  contrib_t              contrib_q;

  assign asd      = word_i.sd[SD_W-1] ? SD_W'(-word_i.sd) : SD_W'(word_i.sd);
  assign as_d     = word_i.scale[SD_W-1] ? SD_W'(-word_i.scale) : SD_W'(word_i.scale);
  assign sd2_full = (2*SD_W)'(asd) * (2*SD_W)'(asd);

  // Derived from the component word; the user must change it only while the block is idle (not enforced here).
  always_ff @(posedge clk_i) begin
    sd2_q <= sd2_full[SD2_W-1:0];
    as_q  <= as_d;
    neg_q <= word_i.scale[SD_W-1];
  end

  assign d    = D_W'($signed({1'b0, x_i})) - (D_W'(word_i.mean) <<< MEAN_SHIFT);
  assign ad_d = d[D_W-1] ? AD_W'(-d) : AD_W'(d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ad_q <= ad_d;
      sq_q <= SQ_W'(ad_q) * SQ_W'(ad_q);
    end
  end

  gsw_div u_div (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .sq_i   (sq_q),
    .sd2_i  (sd2_q),
    .u_o    (u),
    .kill_o (kill_div)
  );

  gsw_exp u_exp (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .u_i    (u),
    .kill_i (kill_div),
    .y_o    (y),
    .kill_o (kill_exp)
  );

  assign rnd = prod_q + (PROD_W'(1) << (Y_SHIFT - 1));
  assign mag = rnd[PROD_W-1:Y_SHIFT];
  assign cm  = contrib_t'({1'b0, mag});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= PROD_W'(as_q) * PROD_W'(y);
      kill_q    <= kill_exp;
      contrib_q <= kill_q ? '0 : (neg_q ? -cm : cm);
    end
  end

  assign contrib_o = contrib_q;

endmodule
`default_nettype wire

// ===== rtl/gaussian_sum_waveform_sample_top.sv =====
// Channel  Direction  Payload
// cfg_i    in         index, data
// in_i     in         time_index, prior_value
// out_o    out        sample_value, saturated
//
// One beat is accepted every clock cycle when the output is free or taken.
// Each beat passes through the 21-step division and the three-stage terms of
// the 12-term exponential series in each lane.
// All stages advance on one common enable, so a stalled output holds every stage.
// Reset clears the configuration registers and all valid bits.
`default_nettype none
`include "assert_macros.svh"
module gaussian_sum_waveform_sample_top
  import gsw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  gsw_cfg_if.sink  cfg_i,
  gsw_in_if.sink   in_i,
  gsw_out_if.source out_o
);

  localparam int XP_W = IDX_W + STEP_W;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SMP_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(SMP_MIN);

  logic [CNT_W-1:0]        count_q;
  logic [STEP_W-1:0]       step_q;
  comp_word_t              word_q [NUM_WORDS];
  logic [CNT_W-1:0]        cnt_eff;

  logic                    en;
  logic [XP_W-1:0]         xp;
  logic [X_W-1:0]          x_q;
  logic [LANE_LAT:0]       vld_q;
  logic signed [SMP_W-1:0] prior_q [0:LANE_LAT];
  logic                    rng_q   [0:LANE_LAT];
  contrib_t                contrib [NUM_WORDS];

  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] acc_q;
  logic                    vld_s_q;

  logic                    out_vld_q;
  logic signed [SMP_W-1:0] smp_q;
  logic                    sat_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      step_q  <= '0;
      word_q  <= '{default: '0};
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_COUNT: count_q   <= cfg_i.data[CNT_W-1:0];
        REG_STEP:  step_q    <= cfg_i.data[STEP_W-1:0];
        REG_WORD0: word_q[0] <= comp_word_t'(cfg_i.data);
        REG_WORD1: word_q[1] <= comp_word_t'(cfg_i.data);
        REG_WORD2: word_q[2] <= comp_word_t'(cfg_i.data);
        REG_WORD3: word_q[3] <= comp_word_t'(cfg_i.data);
        REG_WORD4: word_q[4] <= comp_word_t'(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign cnt_eff = (count_q > CNT_W'(MAX_COMP)) ? CNT_W'(MAX_COMP) : count_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;
  assign xp         = XP_W'(in_i.time_index) * XP_W'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_s_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LANE_LAT-1:0], in_i.valid};
      vld_s_q   <= vld_q[LANE_LAT];
      out_vld_q <= vld_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q        <= xp[XP_W-1:X_SHIFT];
      prior_q[0] <= in_i.prior_value;
      rng_q[0]   <= (int'(in_i.time_index) < SEG_STEPS);
      for (int i = 1; i <= LANE_LAT; i++) begin
        prior_q[i] <= prior_q[i-1];
        rng_q[i]   <= rng_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < NUM_WORDS; k++) begin : g_lane
    gsw_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .word_i    (word_q[k]),
      .x_i       (x_q),
      .contrib_o (contrib[k])
    );
  end

  always_comb begin
    acc_d = ACC_W'(prior_q[LANE_LAT]);
    if (rng_q[LANE_LAT]) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        if (k < int'(cnt_eff)) begin
          acc_d = acc_d + ACC_W'(contrib[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q <= acc_d;
      if (acc_q > ACC_HI) begin
        smp_q <= SMP_MAX;
        sat_q <= 1'b1;
      end else if (acc_q < ACC_LO) begin
        smp_q <= SMP_MIN;
        sat_q <= 1'b1;
      end else begin
        smp_q <= acc_q[SMP_W-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.sample_value = smp_q;
  assign out_o.saturated    = sat_q;

  `GSW_ASSERT(a_enter, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> vld_q[0], "accepted beat lost at entry")
  `GSW_ASSERT(a_hold, clk_i, rst_ni, !en |=> $stable(vld_q), "pipeline moved during a stall")
  `GSW_ASSERT(a_drain, clk_i, rst_ni, (en && vld_s_q) |=> out_vld_q, "summed beat did not reach the output")
  `GSW_NEVER(a_sat, clk_i, rst_ni, out_vld_q && sat_q && smp_q != SMP_MAX && smp_q != SMP_MIN, "clip flag without a clipped value")

endmodule
`default_nettype wire
